// ===== hdl/spsm_pkg.sv =====
// ----------------------------------------------------------------------------
// spsm_pkg
// Shared widths, command codes, heap entry type and ordering for the
// smallest pair sums merger.
// ----------------------------------------------------------------------------
`default_nettype none

package spsm_pkg;

  // sizes
  localparam int MAX_LEN     = 1024;
  localparam int IDX_W       = $clog2(MAX_LEN);
  localparam int LEN_W       = IDX_W + 1;
  localparam int VALUE_W     = 32;
  localparam int SUM_W       = VALUE_W + 1;
  localparam int CFG_W       = 11;
  localparam int FUNC_W      = 2;
  localparam int HEAP_W      = SUM_W + IDX_W;
  localparam int IN_TDATA_W  = ((IDX_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SUM_W + 7) / 8) * 8;

  // command codes on the input stream
  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD_A = 2'd0,
    FN_LOAD_B = 2'd1,
    FN_START  = 2'd2,
    FN_POP    = 2'd3
  } func_t;

  // result status codes
  localparam logic ST_VALID = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

  // one heap entry, sum above column so the packed value orders correctly
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] col;
  } heap_item_t;

  // operations handed to the heap engine
  typedef enum logic [2:0] {
    HOP_NONE     = 3'd0,
    HOP_CLEAR    = 3'd1,
    HOP_PUSH     = 3'd2,
    HOP_READ_TOP = 3'd3,
    HOP_REPLACE  = 3'd4,
    HOP_REMOVE   = 3'd5
  } heap_op_t;

  typedef struct packed {
    heap_op_t   op;
    heap_item_t item;
  } heap_cmd_t;

  typedef struct packed {
    logic             busy;
    logic [LEN_W-1:0] count;
    heap_item_t       rd_item;
  } heap_stat_t;

  // smaller sum first, smaller column on equal sums
  function automatic logic item_less(heap_item_t x, heap_item_t y);
    return {x.sum, x.col} < {y.sum, y.col};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/smallest_pair_sums_merger.sv =====
// ----------------------------------------------------------------------------
// smallest_pair_sums_merger
// Returns pair sums of two loaded ascending sequences in increasing order,
// one per pop command, using a min-heap held in block memory.
// ----------------------------------------------------------------------------
// Load commands write one element of either sequence. A start command
// clears the heap and pushes the first-row sum of every column. A pop
// command gives one result: the smallest pending sum, or status empty
// with sum zero. The next command is taken once the heap engine is
// idle; a result waiting in the output register does not hold off loads or
// starts, only the next result. Entries of the sequence, row pointer and
// heap memories are not cleared at reset and need no clearing pass.
`default_nettype none

module smallest_pair_sums_merger (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [spsm_pkg::IN_TDATA_W-1:0]  in_tdata,   // index, value, zero pad
  input  logic [spsm_pkg::FUNC_W-1:0]      in_tuser,   // func
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [spsm_pkg::OUT_TDATA_W-1:0] out_tdata,  // sum, zero pad
  output logic                             out_tuser,  // status
  // seq_length register
  input  logic                             cfg_we,
  input  logic [spsm_pkg::CFG_W-1:0]       cfg_wdata
);

  import spsm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_A0    = 8'b00000010,
    S_BPUSH = 8'b00000100,
    S_PWAIT = 8'b00001000,
    S_EMPTY = 8'b00010000,
    S_TOP   = 8'b00100000,
    S_RP    = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   seq_len_r;
  logic [VALUE_W-1:0] a0_r, a0_nxt;
  logic [IDX_W-1:0]   col_r, col_nxt;
  heap_item_t         top_r, top_nxt;
  logic [LEN_W-1:0]   row_r, row_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]   out_sum_r;
  logic               out_status_r;

  func_t              in_func;
  logic [IDX_W-1:0]   in_index;
  logic [VALUE_W-1:0] in_value;
  logic               in_xfer;
  logic [LEN_W-1:0]   len_eff;
  logic [LEN_W-1:0]   col_p1;
  logic               out_free;
  logic               out_load;
  logic [SUM_W-1:0]   out_sum_nxt;
  logic               out_status_nxt;

  logic               a_we, a_re, b_we, b_re, rp_we, rp_re;
  logic [IDX_W-1:0]   a_raddr, b_raddr, rp_waddr, rp_raddr;
  logic [LEN_W-1:0]   rp_wdata, rp_rdata, rp_inc;
  logic [VALUE_W-1:0] a_rdata, b_rdata;
  logic [SUM_W-1:0]   pair_sum;

  heap_cmd_t          hcmd;
  heap_stat_t         hstat;

  // stream field unpacking
  assign in_func  = func_t'(in_tuser);
  assign in_index = in_tdata[IDX_W-1:0];
  assign in_value = in_tdata[IDX_W +: VALUE_W];
  assign in_xfer  = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && !hstat.busy;

  // length saturated to the store depth
  assign len_eff = (seq_len_r > CFG_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : LEN_W'(seq_len_r);
  assign col_p1  = LEN_W'(col_r) + 1'b1;

  // row pointer advance, saturating at the store depth
  assign rp_inc   = (rp_rdata == LEN_W'(MAX_LEN)) ? rp_rdata : rp_rdata + 1'b1;
  assign pair_sum = SUM_W'(a_rdata) + SUM_W'(b_rdata);
  assign out_free = !out_valid_r || out_tready;

  // sequence and row pointer stores
  assign a_we = in_xfer && (in_func == FN_LOAD_A);
  assign b_we = in_xfer && (in_func == FN_LOAD_B);

  spsm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_LEN)
  ) u_a_ram (
    .clk     (clk),
    .wr_en   (a_we),
    .wr_addr (in_index),
    .wr_data (in_value),
    .rd_en   (a_re),
    .rd_addr (a_raddr),
    .rd_data (a_rdata)
  );

  spsm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_LEN)
  ) u_b_ram (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (in_index),
    .wr_data (in_value),
    .rd_en   (b_re),
    .rd_addr (b_raddr),
    .rd_data (b_rdata)
  );

  spsm_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MAX_LEN)
  ) u_rp_ram (
    .clk     (clk),
    .wr_en   (rp_we),
    .wr_addr (rp_waddr),
    .wr_data (rp_wdata),
    .rd_en   (rp_re),
    .rd_addr (rp_raddr),
    .rd_data (rp_rdata)
  );

  spsm_heap u_heap (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (hcmd),
    .stat  (hstat)
  );

  // command sequencer
  always_comb begin
    state_nxt      = state_r;
    a0_nxt         = a0_r;
    col_nxt        = col_r;
    top_nxt        = top_r;
    row_nxt        = row_r;
    out_load       = 1'b0;
    out_sum_nxt    = top_r.sum;
    out_status_nxt = ST_VALID;
    a_re           = 1'b0;
    a_raddr        = row_r[IDX_W-1:0];
    b_re           = 1'b0;
    b_raddr        = col_r;
    rp_we          = 1'b0;
    rp_waddr       = col_r;
    rp_wdata       = '0;
    rp_re          = 1'b0;
    rp_raddr       = hstat.rd_item.col;
    hcmd.op        = HOP_NONE;
    hcmd.item.sum  = pair_sum;
    hcmd.item.col  = top_r.col;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_func)
            FN_START: begin
              hcmd.op = HOP_CLEAR;
              col_nxt = '0;
              if (len_eff != '0) begin
                a_re      = 1'b1;
                a_raddr   = '0;
                state_nxt = S_A0;
              end
            end
            FN_POP: begin
              if (hstat.count == '0) begin
                state_nxt = S_EMPTY;
              end else begin
                hcmd.op   = HOP_READ_TOP;
                state_nxt = S_TOP;
              end
            end
            default: ;
          endcase
        end
      end
      S_A0: begin
        a0_nxt    = a_rdata;
        b_re      = 1'b1;
        state_nxt = S_BPUSH;
      end
      S_BPUSH: begin
        // first-row sum of this column, row pointer back to row zero
        hcmd.op       = HOP_PUSH;
        hcmd.item.sum = SUM_W'(a0_r) + SUM_W'(b_rdata);
        hcmd.item.col = col_r;
        rp_we         = 1'b1;
        state_nxt     = S_PWAIT;
      end
      S_PWAIT: begin
        if (!hstat.busy) begin
          if (col_p1 < len_eff) begin
            col_nxt   = col_p1[IDX_W-1:0];
            b_re      = 1'b1;
            b_raddr   = col_p1[IDX_W-1:0];
            state_nxt = S_BPUSH;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_sum_nxt    = '0;
          out_status_nxt = ST_EMPTY;
          state_nxt      = S_IDLE;
        end
      end
      S_TOP: begin
        top_nxt   = hstat.rd_item;
        rp_re     = 1'b1;
        state_nxt = S_RP;
      end
      S_RP: begin
        // advance the column and fetch its next pair
        row_nxt   = rp_inc;
        rp_we     = 1'b1;
        rp_waddr  = top_r.col;
        rp_wdata  = rp_inc;
        a_re      = 1'b1;
        a_raddr   = rp_inc[IDX_W-1:0];
        b_re      = 1'b1;
        b_raddr   = top_r.col;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          hcmd.op   = (row_r < len_eff) ? HOP_REPLACE : HOP_REMOVE;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state and length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seq_len_r   <= CFG_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        seq_len_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    a0_r  <= a0_nxt;
    col_r <= col_nxt;
    top_r <= top_nxt;
    row_r <= row_nxt;
    if (out_load) begin
      out_sum_r    <= out_sum_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_sum_r);
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

// ===== hdl/spsm_ram.sv =====
// ----------------------------------------------------------------------------
// spsm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module spsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/spsm_heap.sv =====
// ----------------------------------------------------------------------------
// spsm_heap
// Min-heap engine over one heap memory: clear, push with sift-up, replace of the
// top or removal of the top with sift-down, and a read of the top entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spsm_heap (
  input  logic                   clk,
  input  logic                   rst_n,
  input  spsm_pkg::heap_cmd_t    cmd,
  output spsm_pkg::heap_stat_t   stat
);

  import spsm_pkg::*;

  typedef enum logic [6:0] {
    H_IDLE   = 7'b0000001,
    H_SU_CHK = 7'b0000010,
    H_SU_CMP = 7'b0000100,
    H_LAST   = 7'b0001000,
    H_SD_CHK = 7'b0010000,
    H_SD_L   = 7'b0100000,
    H_SD_R   = 7'b1000000
  } hstate_t;

  hstate_t          state_r, state_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  heap_item_t       item_r, item_nxt;
  heap_item_t       left_r, left_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  heap_item_t       ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [HEAP_W-1:0] ram_rdata;
  heap_item_t       rd_item;

  logic [LEN_W-1:0] left_idx;
  logic [LEN_W:0]   right_ext;
  logic [IDX_W-1:0] pos_m1;
  logic [IDX_W-1:0] parent_idx;
  logic [LEN_W-1:0] count_m1;

  spsm_ram #(
    .WIDTH (HEAP_W),
    .DEPTH (MAX_LEN)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_item    = ram_rdata;
  assign left_idx   = {pos_r, 1'b1};
  assign right_ext  = {1'b0, left_idx} + 1'b1;
  assign pos_m1     = pos_r - 1'b1;
  assign parent_idx = {1'b0, pos_m1[IDX_W-1:1]};
  assign count_m1   = count_r - 1'b1;

  // sift sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    item_nxt  = item_r;
    left_nxt  = left_r;
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = item_r;
    ram_re    = 1'b0;
    ram_raddr = left_idx[IDX_W-1:0];
    case (state_r)
      H_IDLE: begin
        case (cmd.op)
          HOP_CLEAR: begin
            count_nxt = '0;
          end
          HOP_PUSH: begin
            item_nxt  = cmd.item;
            pos_nxt   = count_r[IDX_W-1:0];
            count_nxt = count_r + 1'b1;
            state_nxt = H_SU_CHK;
          end
          HOP_READ_TOP: begin
            ram_re    = 1'b1;
            ram_raddr = '0;
          end
          HOP_REPLACE: begin
            item_nxt  = cmd.item;
            pos_nxt   = '0;
            state_nxt = H_SD_CHK;
          end
          HOP_REMOVE: begin
            count_nxt = count_m1;
            pos_nxt   = '0;
            // last entry moves to the top unless the heap is now empty
            if (count_m1 != '0) begin
              ram_re    = 1'b1;
              ram_raddr = count_m1[IDX_W-1:0];
              state_nxt = H_LAST;
            end
          end
          default: ;
        endcase
      end
      H_SU_CHK: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = parent_idx;
          state_nxt = H_SU_CMP;
        end
      end
      H_SU_CMP: begin
        ram_we = 1'b1;
        if (item_less(item_r, rd_item)) begin
          // parent moves down one level
          ram_wdata = rd_item;
          pos_nxt   = parent_idx;
          state_nxt = H_SU_CHK;
        end else begin
          state_nxt = H_IDLE;
        end
      end
      H_LAST: begin
        item_nxt  = rd_item;
        state_nxt = H_SD_CHK;
      end
      H_SD_CHK: begin
        if (left_idx >= count_r) begin
          ram_we    = 1'b1;
          state_nxt = H_IDLE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = H_SD_L;
        end
      end
      H_SD_L: begin
        left_nxt = rd_item;
        if (right_ext < {1'b0, count_r}) begin
          ram_re    = 1'b1;
          ram_raddr = right_ext[IDX_W-1:0];
          state_nxt = H_SD_R;
        end else if (item_less(rd_item, item_r)) begin
          ram_we    = 1'b1;
          ram_wdata = rd_item;
          pos_nxt   = left_idx[IDX_W-1:0];
          state_nxt = H_SD_CHK;
        end else begin
          ram_we    = 1'b1;
          state_nxt = H_IDLE;
        end
      end
      H_SD_R: begin
        ram_we = 1'b1;
        if (item_less(rd_item, left_r) && item_less(rd_item, item_r)) begin
          // right child is the smaller and rises
          ram_wdata = rd_item;
          pos_nxt   = right_ext[IDX_W-1:0];
          state_nxt = H_SD_CHK;
        end else if (!item_less(rd_item, left_r) && item_less(left_r, item_r)) begin
          ram_wdata = left_r;
          pos_nxt   = left_idx[IDX_W-1:0];
          state_nxt = H_SD_CHK;
        end else begin
          state_nxt = H_IDLE;
        end
      end
      default: begin
        state_nxt = H_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    item_r <= item_nxt;
    left_r <= left_nxt;
  end

  assign stat.busy    = (state_r != H_IDLE);
  assign stat.count   = count_r;
  assign stat.rd_item = rd_item;

endmodule

`default_nettype wire

// ===== sim/smallest_pair_sums_merger_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smallest_pair_sums_merger_tb
// Self-checking bench for the smallest pair sums merger. A command queue
// feeds the input stream through a clocked driver with random gaps. A clocked
// monitor follows each accepted command in a scoreboard model: a table of one
// pending sum per column, popped by smallest sum then smallest column. It
// checks every returned sum and status against that model. Sequence lengths
// run from zero through the saturated maximum, with restarts, loads mid-run,
// length changes without a restart and pops past the last pending sum.
// ----------------------------------------------------------------------------

module smallest_pair_sums_merger_tb;

  import spsm_pkg::*;

  localparam int ITEM_TARGET     = 1600;
  localparam int BIG_AFTER       = 300;
  localparam int RESET_CYCLES    = 11;
  localparam int SETTLE_CYCLES   = 128;
  localparam int WATCHDOG_LIMIT  = 200000;
  localparam int QUIET_TAIL      = 150;
  localparam int IN_PAD_W        = IN_TDATA_W - IDX_W - VALUE_W;

  typedef struct packed {
    func_t              func;
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] value;
  } merger_cmd_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             status;
  } sum_result_t;

  typedef enum {PH_FRESH, PH_REUSE, PH_CARRY} phase_kind_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // index, value, zero pad
  logic [FUNC_W-1:0]      in_tuser   = '0;   // func
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // sum, zero pad
  logic                   out_tuser;         // status
  logic                   cfg_we     = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata  = '0;

  // stimulus side
  merger_cmd_t cmd_backlog[$];
  bit          a_loaded[MAX_LEN];
  bit          b_loaded[MAX_LEN];
  int          items_queued     = 0;
  int          pops_since_start = 0;
  bit          quiet_tail       = 1'b0;
  int          in_gap           = 0;
  int          in_calm          = 0;

  // scoreboard model of the merger
  logic [VALUE_W-1:0] row_val[MAX_LEN];
  logic [VALUE_W-1:0] col_val[MAX_LEN];
  int unsigned        row_ptr[MAX_LEN];
  bit                 live[MAX_LEN];
  logic [SUM_W-1:0]   live_sum[MAX_LEN];
  int                 live_n     = 0;
  logic [CFG_W-1:0]   length_reg = 11'd1;
  sum_result_t        pending_sums[$];

  // monitor side
  int mismatches = 0;
  int stuck      = 0;
  int out_stall  = 0;
  int out_calm   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  smallest_pair_sums_merger dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // advance the model by one accepted command, returns 1 when a result is due
  function automatic bit step_pair_merge(input func_t f, input logic [IDX_W-1:0] idx,
                                         input logic [VALUE_W-1:0] v,
                                         output sum_result_t res);
    int unsigned len;
    int          best;
    int unsigned r;
    len = (length_reg > MAX_LEN) ? MAX_LEN : length_reg;
    res = '0;
    case (f)
      FN_LOAD_A: begin
        row_val[idx] = v;
        return 1'b0;
      end
      FN_LOAD_B: begin
        col_val[idx] = v;
        return 1'b0;
      end
      FN_START: begin
        // every column restarts on the first row
        for (int c = 0; c < MAX_LEN; c++) begin
          live[c] = (c < len);
          if (c < len) begin
            row_ptr[c]  = 0;
            live_sum[c] = {1'b0, row_val[0]} + {1'b0, col_val[c]};
          end
        end
        live_n = len;
        return 1'b0;
      end
      default: begin
        if (live_n == 0) begin
          res.status = ST_EMPTY;
          return 1'b1;
        end
        // smallest sum wins, lower column on a tie
        best = -1;
        for (int c = 0; c < MAX_LEN; c++)
          if (live[c] && (best < 0 || live_sum[c] < live_sum[best]))
            best = c;
        res.sum    = live_sum[best];
        res.status = ST_VALID;
        live[best] = 1'b0;
        live_n--;
        // next row of that column while rows remain
        r = row_ptr[best] + 1;
        if (r > MAX_LEN)
          r = MAX_LEN;
        row_ptr[best] = r;
        if (r < len) begin
          live[best]     = 1'b1;
          live_sum[best] = {1'b0, row_val[r]} + {1'b0, col_val[best]};
          live_n++;
        end
        return 1'b1;
      end
    endcase
  endfunction

  // command driver, gaps only between transfers
  always @(posedge clk) begin : command_driver
    merger_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap == 0 && !quiet_tail) begin
        if (in_calm != 0)
          in_calm--;
        else if ($urandom_range(0, 31) == 0)
          in_calm = $urandom_range(20, 400);
        else if ($urandom_range(0, 5) == 0)
          in_gap = $urandom_range(1, 19);
      end
      if (in_gap != 0 || cmd_backlog.size() == 0) begin
        in_tvalid <= 1'b0;
        if (in_gap != 0)
          in_gap--;
      end else begin
        c = cmd_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= c.func;
        in_tdata  <= {{IN_PAD_W{1'b0}}, c.value, c.idx};
      end
    end
  end

  // result monitor, scoreboard update, watchdog and receiver stalls
  always @(posedge clk) begin : result_monitor
    sum_result_t got;
    sum_result_t want;
    sum_result_t fresh;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      // result transfer against the oldest pending sum
      if (out_tvalid && out_tready) begin
        got.sum    = out_tdata[SUM_W-1:0];
        got.status = out_tuser;
        if (pending_sums.size() == 0) begin
          $error("unexpected result: sum %0h status %0b", got.sum, got.status);
          mismatches++;
        end else begin
          want = pending_sums.pop_front();
          if (got.sum !== want.sum) begin
            $error("sum: expected %0h, actual %0h", want.sum, got.sum);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0b, actual %0b", want.status, got.status);
            mismatches++;
          end
        end
      end

      // command transfer into the model
      if (in_tvalid && in_tready) begin
        if (step_pair_merge(func_t'(in_tuser), in_tdata[IDX_W-1:0],
                            in_tdata[IDX_W +: VALUE_W], fresh))
          pending_sums = {pending_sums, fresh};
      end
      if (cfg_we)
        length_reg = cfg_wdata;

      // watchdog on cycles without any transfer
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stuck = 0;
      end else begin
        stuck++;
        if (stuck >= WATCHDOG_LIMIT) begin
          $display("[smallest_pair_sums_merger] ERROR");
          $finish;
        end
      end

      // receiver stalls in bursts
      if (out_stall == 0 && !quiet_tail) begin
        if (out_calm != 0)
          out_calm--;
        else if ($urandom_range(0, 31) == 0)
          out_calm = $urandom_range(20, 400);
        else if ($urandom_range(0, 5) == 0)
          out_stall = $urandom_range(1, 19);
      end
      if (out_stall != 0) begin
        out_tready <= 1'b0;
        out_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_cmd(input func_t f, input int unsigned idx,
                           input logic [VALUE_W-1:0] v);
    merger_cmd_t c;
    c.func  = f;
    c.idx   = idx[IDX_W-1:0];
    c.value = v;
    cmd_backlog = {cmd_backlog, c};
    items_queued++;
    if (f == FN_LOAD_A)
      a_loaded[c.idx] = 1'b1;
    if (f == FN_LOAD_B)
      b_loaded[c.idx] = 1'b1;
    // each pop moves one column at most one row on
    if (f == FN_START)
      pops_since_start = 0;
    if (f == FN_POP)
      pops_since_start++;
  endtask

  // all commands done, all results back, engine given time to finish
  task automatic wait_idle();
    do
      @(negedge clk);
    while (cmd_backlog.size() != 0 || in_tvalid || pending_sums.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_length(input logic [CFG_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // one sequence, mostly ascending with ties and saturation near the top
  task automatic queue_sequence(input func_t f, input int n);
    logic [VALUE_W:0]   acc;
    logic [VALUE_W-1:0] step_max;
    bit                 unordered;
    unordered = ($urandom_range(0, 5) == 0);
    case ($urandom_range(0, 3))
      0:       acc = '0;
      1:       acc = (VALUE_W+1)'($urandom_range(0, 100));
      2:       acc = {1'b0, $urandom};
      default: acc = {1'b0, 32'hFFFF_FF00} + (VALUE_W+1)'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 3))
      0:       step_max = 3;
      1:       step_max = 1000;
      2:       step_max = 32'h00FF_FFFF;
      default: step_max = $urandom;
    endcase
    for (int i = 0; i < n; i++) begin
      if (unordered) begin
        queue_cmd(f, i, $urandom);
      end else begin
        queue_cmd(f, i, acc[VALUE_W-1:0]);
        acc = acc + (VALUE_W+1)'($urandom_range(0, step_max));
        if (acc[VALUE_W])
          acc = {1'b0, {VALUE_W{1'b1}}};
      end
    end
  endtask

  // fill any element a start or a later push could read
  task automatic ensure_loaded(input int a_rows, input int n);
    for (int i = 0; i < n; i++) begin
      if (i < a_rows && !a_loaded[i])
        queue_cmd(FN_LOAD_A, i, $urandom);
      if (!b_loaded[i])
        queue_cmd(FN_LOAD_B, i, $urandom);
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] len_cfg, input phase_kind_t kind);
    int n;
    int ops;
    int roll;
    int reach;
    int a_rows;
    n = (len_cfg > MAX_LEN) ? MAX_LEN : len_cfg;
    ops = (n * n + 3 < 60) ? n * n + 3 : 60;
    ops = $urandom_range(1, ops);
    // rows of the first sequence that pops can reach before the next start
    reach  = (kind == PH_CARRY) ? pops_since_start + ops + 2 : ops + 2;
    a_rows = (reach < n) ? reach : n;
    set_length(len_cfg);
    if (kind == PH_FRESH) begin
      queue_sequence(FN_LOAD_A, a_rows);
      queue_sequence(FN_LOAD_B, n);
    end else begin
      ensure_loaded(a_rows, n);
    end
    // a carried phase keeps the old heap under the new length
    if (kind != PH_CARRY)
      queue_cmd(FN_START, $urandom, $urandom);
    for (int k = 0; k < ops; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 84)
        queue_cmd(FN_POP, $urandom, $urandom);
      else if (roll < 92)
        queue_cmd($urandom_range(0, 1) ? FN_LOAD_B : FN_LOAD_A,
                  $urandom_range(0, MAX_LEN - 1), $urandom);
      else if (roll < 96 && n > 0)
        queue_cmd(FN_LOAD_A, $urandom_range(0, n - 1), $urandom);
      else
        queue_cmd(FN_START, $urandom, $urandom);
    end
    // end on a pop so the last result marks the engine as nearly idle
    queue_cmd(FN_POP, $urandom, $urandom);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] len_cfg;
    phase_kind_t      kind;
    int               roll;
    bit               big_done;
    bit               full_done;
    big_done  = 1'b0;
    full_done = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // heap empty straight after reset, length one
    queue_cmd(FN_POP, $urandom, $urandom);
    // widest values give the largest sum, then the heap runs dry
    queue_cmd(FN_LOAD_A, 0, '1);
    queue_cmd(FN_LOAD_B, 0, '1);
    queue_cmd(FN_START, $urandom, $urandom);
    queue_cmd(FN_POP, $urandom, $urandom);
    queue_cmd(FN_POP, $urandom, $urandom);
    // a valid zero sum next to the empty answer
    queue_cmd(FN_LOAD_A, 0, '0);
    queue_cmd(FN_LOAD_B, 0, '0);
    queue_cmd(FN_START, $urandom, $urandom);
    queue_cmd(FN_POP, $urandom, $urandom);
    // top index of both stores
    queue_cmd(FN_LOAD_A, MAX_LEN - 1, 32'h8000_0001);
    queue_cmd(FN_LOAD_B, MAX_LEN - 1, 32'h7FFF_FFFE);

    // equal sums across columns, then a restart part way through
    set_length(11'd3);
    queue_cmd(FN_LOAD_A, 0, 32'd5);
    queue_cmd(FN_LOAD_A, 1, 32'd5);
    queue_cmd(FN_LOAD_A, 2, 32'd9);
    queue_cmd(FN_LOAD_B, 0, 32'd1);
    queue_cmd(FN_LOAD_B, 1, 32'd1);
    queue_cmd(FN_LOAD_B, 2, 32'd2);
    queue_cmd(FN_START, $urandom, $urandom);
    queue_cmd(FN_POP, $urandom, $urandom);
    queue_cmd(FN_POP, $urandom, $urandom);
    queue_cmd(FN_START, $urandom, $urandom);
    repeat (4) queue_cmd(FN_POP, $urandom, $urandom);

    // random phases, one saturated length and one full length among them
    while (items_queued < ITEM_TARGET) begin
      if (items_queued + QUIET_TAIL >= ITEM_TARGET)
        quiet_tail = 1'b1;
      if (!big_done && items_queued >= BIG_AFTER) begin
        run_phase({CFG_W{1'b1}}, PH_FRESH);
        big_done = 1'b1;
      end else if (big_done && !full_done) begin
        run_phase(CFG_W'(MAX_LEN), PH_REUSE);
        full_done = 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 5)
          len_cfg = '0;
        else if (roll < 70)
          len_cfg = CFG_W'($urandom_range(1, 6));
        else if (roll < 92)
          len_cfg = CFG_W'($urandom_range(7, 40));
        else
          len_cfg = CFG_W'($urandom_range(41, 120));
        roll = $urandom_range(0, 99);
        kind = (roll < 15) ? PH_CARRY : (roll < 25) ? PH_REUSE : PH_FRESH;
        run_phase(len_cfg, kind);
      end
    end

    wait_idle();
    if (mismatches == 0)
      $display("[smallest_pair_sums_merger] OK");
    else
      $display("[smallest_pair_sums_merger] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/spsm_pkg.sv
hdl/spsm_ram.sv
hdl/spsm_heap.sv
hdl/smallest_pair_sums_merger.sv
sim/smallest_pair_sums_merger_tb.sv
